>>> sv/spq_pkg.sv
// shared constants and status codes for the sorted priority queue
package spq_pkg;

    // payload and register widths
    localparam int VAL_W = 32;
    localparam int CAP_W = 7;
    localparam int STATUS_W = 2;

    // default storage depth and capacity after reset
    localparam int DEPTH_DEF = 64;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // operation codes
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

endpackage

>>> sv/sorted_priority_queue_core.sv
// sorted priority queue: min-first store kept in ascending order, one entry moved per cycle
//
// Usage: raise start with operation and value while busy is low; the transfer
// happens at that clock edge. operation 0 inserts value after any equal entries,
// operation 1 removes the smallest entry. Every transfer yields one result:
// done is high for exactly one cycle with status, removed_value and count_after.
// The receiver cannot stall; it must take the result in that cycle.
// Steps: an enqueue moves each greater entry up one slot, then writes the value;
// a dequeue captures the head, then moves each remaining entry down one slot;
// done rises in the cycle in which busy falls. Overflow and underflow leave busy
// low and give done in the cycle after the start. The work is done by the single
// compare-and-move step over the entry memory, which reads one entry and writes at most one entry each cycle.
// A new start may be taken in the cycle in which done is high.
// capacity is written with capacity_we, by the user only while the queue is idle
// (the block does not enforce this); it limits the held entries to min(capacity, DEPTH).
// Reset empties the queue and sets capacity to 64; the entry memory is not
// cleared, since only live entries are ever read.
module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                operation,
    input  logic [VAL_W-1:0]    value,
    input  logic                capacity_we,
    input  logic [CAP_W-1:0]    capacity,
    output logic                done,
    output logic [STATUS_W-1:0] status,
    output logic [VAL_W-1:0]    removed_value,
    output logic [CW-1:0]       count_after
);

    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_ECMP   = 3'd1;
    localparam logic [2:0] S_EPUT   = 3'd2;
    localparam logic [2:0] S_DHEAD  = 3'd3;
    localparam logic [2:0] S_DSHIFT = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [CAP_W-1:0]    capacity_reg;
    logic                done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]    removed_reg, removed_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    logic                full;
    logic [CW-1:0]       count_m1;
    logic [CW-1:0]       idx_p1;
    logic                moves_up;

    spq_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // full when at configured capacity or at storage depth
    assign full = (LW'(count_reg) >= LW'(capacity_reg)) || (count_reg >= CW'(DEPTH));
    assign count_m1 = count_reg - CW'(1);
    assign idx_p1 = CW'(idx_reg) + CW'(1);

    // signed compare: held entry strictly greater than the new value
    assign moves_up = $signed(ram_rdata) > $signed(val_reg);

    // capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (capacity_we)
        begin
            capacity_reg <= capacity;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // working and result payload
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        idx_reg     <= idx_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        removed_reg <= removed_next;
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        val_next     = val_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        removed_next = removed_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = val_reg;
        ram_raddr    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    removed_next = '0;
                    if (operation == OP_ENQUEUE)
                    begin
                        if (full)
                        begin
                            status_next = ST_OVERFLOW;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            val_next = value;
                            pos_next = count_reg[AW-1:0];
                            if (count_reg == '0)
                            begin
                                state_next = S_EPUT;
                            end
                            else
                            begin
                                ram_raddr  = count_m1[AW-1:0];
                                state_next = S_ECMP;
                            end
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = ST_UNDERFLOW;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            ram_raddr  = '0;
                            state_next = S_DHEAD;
                        end
                    end
                end
            end

            // move a greater entry up one slot, or drop the value in place
            S_ECMP:
            begin
                ram_we = 1'b1;
                if (moves_up)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = S_EPUT;
                    end
                    else
                    begin
                        ram_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    count_next  = count_reg + CW'(1);
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            // value goes to the head slot or into an empty queue
            S_EPUT:
            begin
                ram_we      = 1'b1;
                count_next  = count_reg + CW'(1);
                status_next = ST_OK;
                done_next   = 1'b1;
                state_next  = S_IDLE;
            end

            // capture the smallest entry
            S_DHEAD:
            begin
                removed_next = ram_rdata;
                if (count_reg == CW'(1))
                begin
                    count_next  = '0;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    ram_raddr  = AW'(1);
                    idx_next   = AW'(1);
                    state_next = S_DSHIFT;
                end
            end

            // move each remaining entry down one slot
            S_DSHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg - AW'(1);
                ram_wdata = ram_rdata;
                if (idx_p1 < count_reg)
                begin
                    ram_raddr = idx_p1[AW-1:0];
                    idx_next  = idx_p1[AW-1:0];
                end
                else
                begin
                    count_next  = count_m1;
                    status_next = ST_OK;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign removed_value = removed_reg;
    assign count_after   = count_reg;

    // an accepted transfer is either in progress or reported on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
    else $error("accepted transfer neither in progress nor reported");

    // every result comes from a transfer or from finished work
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start)))
    else $error("result without a transfer");

    // failed operations return no value
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status != ST_OK)) |-> (removed_value == '0))
    else $error("removed value on a failed operation");

    // underflow only on an empty queue
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == ST_UNDERFLOW)) |-> (count_after == '0))
    else $error("underflow with entries held");

    // held entries never exceed the storage depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
    else $error("entry count beyond depth");

endmodule

>>> sv/spq_ram.sv
// entry store: one write port, one read port with registered read data
module spq_ram
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int AW = $clog2(DEPTH)
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [VAL_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [VAL_W-1:0] rdata
);

    logic [VAL_W-1:0] mem_reg [DEPTH];
    logic [VAL_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> tb/spq_checker.sv
// checker for the sorted priority queue: predicts each result and compares it
`timescale 1ns / 1ps

module spq_checker
    import spq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CNT_W = $clog2(DEPTH + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  logic                operation,
    input  logic [VAL_W-1:0]    value,
    input  logic                capacity_we,
    input  logic [CAP_W-1:0]    capacity,
    input  logic                done,
    input  logic [STATUS_W-1:0] status,
    input  logic [VAL_W-1:0]    removed_value,
    input  logic [CNT_W-1:0]    count_after,
    output int                  error_count,
    output int                  outstanding
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    removed;
        logic [CNT_W-1:0]    count;
    } queue_result_t;

    // predicted results still waiting for their done strobe
    queue_result_t awaited_results[$];
    // mirror of the live entries, ascending, equal values in arrival order
    logic signed [VAL_W-1:0] held_values[$];
    logic [CAP_W-1:0] capacity_reg;
    queue_result_t oldest;

    initial error_count = 0;

    // apply one operation to the mirrored queue and return its result
    function automatic queue_result_t apply_queue_op(input logic op,
                                                     input logic signed [VAL_W-1:0] val);
        queue_result_t res;
        int limit;
        int pos;
        res = '0;
        limit = (capacity_reg > DEPTH) ? DEPTH : int'(capacity_reg);
        if (op == OP_ENQUEUE) begin
            if (held_values.size() >= limit) begin
                res.status = ST_OVERFLOW;
            end
            else begin
                // insert after every entry that is not greater
                pos = held_values.size();
                while (pos > 0 && held_values[pos-1] > val)
                    pos--;
                held_values.insert(pos, val);
            end
        end
        else if (held_values.size() == 0) begin
            res.status = ST_UNDERFLOW;
        end
        else begin
            res.removed = held_values.pop_front();
        end
        res.count = CNT_W'(held_values.size());
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_values.delete();
            awaited_results.delete();
            capacity_reg = CAP_RESET;
        end
        else begin
            // compare the result strobe against the oldest prediction
            if (done) begin
                if (awaited_results.size() == 0) begin
                    $error("result with no transfer waiting: status %0d removed %0d count %0d",
                           status, $signed(removed_value), count_after);
                    error_count++;
                end
                else begin
                    oldest = awaited_results.pop_front();
                    if (status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, status);
                        error_count++;
                    end
                    if (removed_value !== oldest.removed) begin
                        $error("removed_value: expected %0d, actual %0d",
                               $signed(oldest.removed), $signed(removed_value));
                        error_count++;
                    end
                    if (count_after !== oldest.count) begin
                        $error("count_after: expected %0d, actual %0d",
                               oldest.count, count_after);
                        error_count++;
                    end
                end
            end
            // predict on each accepted transfer
            if (start && !busy)
                awaited_results.push_back(apply_queue_op(operation, value));
            // register write takes effect after this edge
            if (capacity_we)
                capacity_reg = capacity;
        end
        outstanding = awaited_results.size();
    end

endmodule

>>> tb/sorted_priority_queue_core_tb.sv
// testbench top for the sorted priority queue: stimulus, clock, reset and verdict
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH_DEF + 1);
    localparam int CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                operation;
    logic [VAL_W-1:0]    value;
    logic                capacity_we;
    logic [CAP_W-1:0]    capacity;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    removed_value;
    logic [CNT_W-1:0]    count_after;

    int error_count;
    int outstanding;
    int cycle_count;
    int burst_left;
    int idle_cycles;

    sorted_priority_queue_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .value         (value),
        .capacity_we   (capacity_we),
        .capacity      (capacity),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .count_after   (count_after)
    );

    spq_checker #(.DEPTH(DEPTH_DEF), .CNT_W(CNT_W)) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .value         (value),
        .capacity_we   (capacity_we),
        .capacity      (capacity),
        .done          (done),
        .status        (status),
        .removed_value (removed_value),
        .count_after   (count_after),
        .error_count   (error_count),
        .outstanding   (outstanding)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // run limit
    initial cycle_count = 0;
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // mix of full-range, near-zero, extreme and small values
    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] v;
        case ($urandom_range(0, 4))
            0, 1: v = $urandom();
            2: v = $urandom_range(0, 8) - 4;
            3: begin
                case ($urandom_range(0, 3))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom_range(0, 255);
        endcase
        return v;
    endfunction

    // one transfer, with the idle gap of the previous burst in front
    task automatic send_item(input logic op, input logic [VAL_W-1:0] val);
        if (idle_cycles > 0) begin
            start <= 1'b0;
            repeat (idle_cycles) @(posedge clk);
            idle_cycles = 0;
        end
        start     <= 1'b1;
        operation <= op;
        value     <= val;
        do @(posedge clk); while (busy);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left  = $urandom_range(1, 20);
            idle_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
    endtask

    // stop sending and wait for every outstanding result
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        capacity_we <= 1'b1;
        capacity    <= cap;
        @(posedge clk);
        capacity_we <= 1'b0;
    endtask

    initial begin
        int n_items;
        int enq_pct;
        logic [CAP_W-1:0] cap;

        rst_n       = 1'b0;
        start       = 1'b0;
        operation   = OP_ENQUEUE;
        value       = '0;
        capacity_we = 1'b0;
        capacity    = CAP_RESET;
        burst_left  = $urandom_range(1, 20);
        idle_cycles = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, extremes, equal values
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_ENQUEUE, 32'h8000_0000);
        send_item(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_item(OP_ENQUEUE, 32'h0000_0000);
        send_item(OP_ENQUEUE, 32'hFFFF_FFFF);
        send_item(OP_ENQUEUE, 32'h0000_0000);
        send_item(OP_ENQUEUE, 32'h0000_0001);
        send_item(OP_ENQUEUE, 32'h7FFF_FFFF);
        send_item(OP_ENQUEUE, 32'h8000_0000);
        send_item(OP_DEQUEUE, 32'hFFFF_FFFF);
        send_item(OP_DEQUEUE, 32'h0000_0000);
        send_item(OP_DEQUEUE, $urandom());
        drain();

        // capacity lowered below the held count
        write_capacity(7'd2);
        send_item(OP_ENQUEUE, 32'h0000_0005);
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_ENQUEUE, 32'h0000_0003);
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_ENQUEUE, 32'hFFFF_FFFE);
        drain();

        // zero capacity: enqueues overflow, dequeues still drain
        write_capacity(7'd0);
        send_item(OP_ENQUEUE, 32'h0000_0007);
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_DEQUEUE, $urandom());
        send_item(OP_DEQUEUE, $urandom());
        drain();

        // random phases, each under its own capacity
        for (int phase = 0; phase < 10; phase++) begin
            if (phase == 0) begin
                // above the depth: fill to the top and overflow
                cap = 7'd127;
                n_items = 90;
                enq_pct = 90;
            end
            else if (phase == 1) begin
                cap = CAP_W'(DEPTH_DEF);
                n_items = 50;
                enq_pct = 30;
            end
            else begin
                case ($urandom_range(0, 5))
                    0: cap = 7'd0;
                    1: cap = CAP_W'($urandom_range(65, 127));
                    2: cap = CAP_W'(DEPTH_DEF);
                    default: cap = CAP_W'($urandom_range(1, 12));
                endcase
                n_items = $urandom_range(35, 55);
                enq_pct = $urandom_range(30, 75);
            end
            write_capacity(cap);
            for (int i = 0; i < n_items; i++) begin
                if ($urandom_range(1, 100) <= enq_pct)
                    send_item(OP_ENQUEUE, pick_value());
                else
                    send_item(OP_DEQUEUE, $urandom());
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0 && outstanding == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> sorted_priority_queue_core.f
sv/spq_pkg.sv
sv/spq_ram.sv
sv/sorted_priority_queue_core.sv
tb/spq_checker.sv
tb/sorted_priority_queue_core_tb.sv
